### design/coab_pkg.sv
`default_nettype none

package coab_pkg;

    localparam int DEFAULT_IMAGE_WIDTH  = 64;
    localparam int DEFAULT_IMAGE_HEIGHT = 64;

    localparam int COORD_W = 6;
    localparam int COLOR_W = 8;
    localparam int SQ_W    = 2 * COORD_W;

    // divide by a hundred: floor(x * 5243 / 2^19) is exact for x below 43690
    localparam logic [6:0]  PERCENT_FULL = 7'd100;
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int          RECIP_SHIFT  = 19;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DRAW  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // register index, byte address 4 * index on the apb port
    typedef enum logic [2:0] {
        REG_CENTER_COL = 3'd0,
        REG_CENTER_ROW = 3'd1,
        REG_RADIUS     = 3'd2,
        REG_INK_RED    = 3'd3,
        REG_INK_GREEN  = 3'd4,
        REG_INK_BLUE   = 3'd5,
        REG_OPACITY    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] root;
    } coab_sqrt_stat_t;

endpackage

`default_nettype wire

### design/coab_isqrt.sv
`default_nettype none

module coab_isqrt
    import coab_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [COORD_W-1:0] radius,
    input  wire logic [COORD_W-1:0] index,
    output coab_sqrt_stat_t         stat
);

    localparam int BIT_W = $clog2(COORD_W);

    logic [SQ_W-1:0]    value_reg;
    logic [COORD_W-1:0] root_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [SQ_W-1:0]    rad_sq;
    logic [SQ_W-1:0]    idx_sq;
    logic [COORD_W-1:0] trial;
    logic [SQ_W-1:0]    trial_sq;

    assign rad_sq   = SQ_W'(radius) * SQ_W'(radius);
    assign idx_sq   = SQ_W'(index) * SQ_W'(index);
    assign trial    = root_reg | (COORD_W'(1) << bit_reg);
    assign trial_sq = SQ_W'(trial) * SQ_W'(trial);

    // one result bit per cycle, most significant first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            root_reg  <= '0;
            bit_reg   <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // index beyond the radius gives a root of zero
                value_reg <= (radius >= index) ? (rad_sq - idx_sq) : '0;
                root_reg  <= '0;
                bit_reg   <= BIT_W'(COORD_W - 1);
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (trial_sq <= value_reg)
                begin
                    root_reg <= trial;
                end
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - BIT_W'(1);
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.root = root_reg;

endmodule

`default_nettype wire

### design/circle_outline_alpha_blend_core.sv
`default_nettype none

// circle outline drawing with alpha blending into an rgb frame store of
// IMAGE_WIDTH x IMAGE_HEIGHT pixels (24 bit, red in the top byte). beats on
// the request channel write a pixel, read a pixel back or run one draw step
// that blends up to four outline points with the ink colour; every request
// beat gives exactly one response beat. the block works on one request at a
// time. a pixel write and a pixel read both depend on the synchronous frame
// memory with its registered read. a draw step runs the bit-serial square
// root and its hand-over, then per point inside the image one memory read,
// the weighted sum and the divide by a hundred with the write back, while a
// point outside is only checked; then come the response and an idle state.
// registers sit at byte address 4 * index on the apb port and should only be
// written while no request is in flight. the frame store has no reset; a
// pixel must be written before it is read or blended.
module circle_outline_alpha_blend_core
    import coab_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEFAULT_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEFAULT_IMAGE_HEIGHT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output      logic [31:0]        prdata,
    output      logic               pready,

    input  wire logic               req_valid,
    output      logic               req_stall,
    input  wire logic [1:0]         kind,
    input  wire logic [COORD_W-1:0] pixel_col,
    input  wire logic [COORD_W-1:0] pixel_row,
    input  wire logic [COLOR_W-1:0] load_red,
    input  wire logic [COLOR_W-1:0] load_green,
    input  wire logic [COLOR_W-1:0] load_blue,
    input  wire logic [COORD_W-1:0] step_index,
    input  wire logic               pass_select,

    output      logic               rsp_valid,
    input  wire logic               rsp_stall,
    output      logic [COLOR_W-1:0] read_red,
    output      logic [COLOR_W-1:0] read_green,
    output      logic [COLOR_W-1:0] read_blue,
    output      logic [2:0]         points_blended
);

    localparam int DEPTH   = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PIX_W   = 3 * COLOR_W;
    localparam int SUM_W   = 15;
    localparam int PROD_W  = SUM_W + 13;
    localparam int PT_W    = COORD_W + 2;
    localparam logic [12:0] W_LIM = 13'(IMAGE_WIDTH);
    localparam logic [12:0] H_LIM = 13'(IMAGE_HEIGHT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDPIX,
        S_SQRT,
        S_PT,
        S_MIX,
        S_WRITE,
        S_FIN
    } state_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [COORD_W-1:0] center_col_reg;
    logic [COORD_W-1:0] center_row_reg;
    logic [COORD_W-1:0] radius_reg;
    logic [COLOR_W-1:0] ink_red_reg;
    logic [COLOR_W-1:0] ink_green_reg;
    logic [COLOR_W-1:0] ink_blue_reg;
    logic [6:0]         opacity_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    // register index = paddr[4:2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg <= '0;
            center_row_reg <= '0;
            radius_reg     <= '0;
            ink_red_reg    <= '0;
            ink_green_reg  <= '0;
            ink_blue_reg   <= '0;
            opacity_reg    <= PERCENT_FULL;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CENTER_COL: center_col_reg <= pwdata[COORD_W-1:0];
                REG_CENTER_ROW: center_row_reg <= pwdata[COORD_W-1:0];
                REG_RADIUS:     radius_reg     <= pwdata[COORD_W-1:0];
                REG_INK_RED:    ink_red_reg    <= pwdata[COLOR_W-1:0];
                REG_INK_GREEN:  ink_green_reg  <= pwdata[COLOR_W-1:0];
                REG_INK_BLUE:   ink_blue_reg   <= pwdata[COLOR_W-1:0];
                REG_OPACITY:    opacity_reg    <= pwdata[6:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_CENTER_COL: prdata = 32'(center_col_reg);
            REG_CENTER_ROW: prdata = 32'(center_row_reg);
            REG_RADIUS:     prdata = 32'(radius_reg);
            REG_INK_RED:    prdata = 32'(ink_red_reg);
            REG_INK_GREEN:  prdata = 32'(ink_green_reg);
            REG_INK_BLUE:   prdata = 32'(ink_blue_reg);
            REG_OPACITY:    prdata = 32'(opacity_reg);
            default:        prdata = '0;
        endcase
    end

    // opacity above a hundred saturates
    logic [6:0] op_sat;
    logic [6:0] op_inv;
    assign op_sat = (opacity_reg > PERCENT_FULL) ? PERCENT_FULL : opacity_reg;
    assign op_inv = PERCENT_FULL - op_sat;

    // ---------------------------------------------------------------
    // helpers
    // ---------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [6:0] row,
                                                   input logic [6:0] col);
        pix_addr = ADDR_W'(32'(row) * 32'(IMAGE_WIDTH) + 32'(col));
    endfunction

    // coordinate carries a sign in its top bit
    function automatic logic coord_ok(input logic [PT_W-1:0] v,
                                      input logic [12:0] lim);
        coord_ok = !v[PT_W-1] && (13'(v[PT_W-2:0]) < lim);
    endfunction

    function automatic logic [SUM_W-1:0] mix_sum(input logic [COLOR_W-1:0] old,
                                                 input logic [COLOR_W-1:0] ink,
                                                 input logic [6:0] inv,
                                                 input logic [6:0] op);
        mix_sum = SUM_W'(SUM_W'(inv) * SUM_W'(old)) + SUM_W'(SUM_W'(op) * SUM_W'(ink));
    endfunction

    function automatic logic [COLOR_W-1:0] div100(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(RECIP_100);
        div100 = p[RECIP_SHIFT +: COLOR_W];
    endfunction

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    state_t state_reg;

    logic               req_accept;
    logic               rsp_free;
    logic               pix_ok;
    logic [ADDR_W-1:0]  pix_a;

    logic [COORD_W-1:0] idx_reg;
    logic               pass_reg;
    logic [COORD_W-1:0] dist_reg;
    logic [1:0]         pt_reg;
    logic [2:0]         cnt_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [SUM_W-1:0]   sum_r_reg;
    logic [SUM_W-1:0]   sum_g_reg;
    logic [SUM_W-1:0]   sum_b_reg;
    logic [PIX_W-1:0]   res_pix_reg;

    logic               rsp_valid_reg;
    logic [PIX_W-1:0]   rsp_pix_reg;
    logic [2:0]         rsp_cnt_reg;

    coab_sqrt_stat_t    sq_stat;
    logic               sq_start;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign pix_ok     = (13'(pixel_col) < W_LIM) && (13'(pixel_row) < H_LIM);
    assign pix_a      = pix_addr(7'(pixel_row), 7'(pixel_col));
    assign sq_start   = req_accept && (kind_t'(kind) == KIND_DRAW);

    coab_isqrt u_isqrt
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .radius (radius_reg),
        .index  (step_index),
        .stat   (sq_stat)
    );

    // current outline point: pass 0 steps the row by i and the column by d,
    // pass 1 the other way round
    logic [COORD_W-1:0] row_off;
    logic [COORD_W-1:0] col_off;
    logic               row_neg;
    logic               col_neg;
    logic [PT_W-1:0]    pt_row;
    logic [PT_W-1:0]    pt_col;
    logic               pt_ok;
    logic [ADDR_W-1:0]  pt_a;

    assign row_off = pass_reg ? dist_reg : idx_reg;
    assign col_off = pass_reg ? idx_reg : dist_reg;
    assign row_neg = pt_reg[0];
    assign col_neg = pass_reg ? pt_reg[1] : !pt_reg[1];
    assign pt_row  = row_neg ? (PT_W'(center_row_reg) - PT_W'(row_off))
                             : (PT_W'(center_row_reg) + PT_W'(row_off));
    assign pt_col  = col_neg ? (PT_W'(center_col_reg) - PT_W'(col_off))
                             : (PT_W'(center_col_reg) + PT_W'(col_off));
    assign pt_ok   = coord_ok(pt_row, H_LIM) && coord_ok(pt_col, W_LIM);
    assign pt_a    = pix_addr(pt_row[PT_W-2:0], pt_col[PT_W-2:0]);

    // ---------------------------------------------------------------
    // frame store: one write and one registered read per cycle
    // ---------------------------------------------------------------
    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [PIX_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [PIX_W-1:0] blended;

    assign blended   = {div100(sum_r_reg), div100(sum_g_reg), div100(sum_b_reg)};
    assign mem_we    = (state_reg == S_WRITE)
                    || (req_accept && (kind_t'(kind) == KIND_WRITE) && pix_ok);
    assign mem_waddr = (state_reg == S_WRITE) ? addr_reg : pix_a;
    assign mem_wdata = (state_reg == S_WRITE) ? blended
                                              : {load_red, load_green, load_blue};
    assign mem_raddr = (state_reg == S_PT) ? pt_a : pix_a;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= frame_mem[mem_raddr];
    end

    // ---------------------------------------------------------------
    // sequencer and response register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            pass_reg      <= 1'b0;
            dist_reg      <= '0;
            pt_reg        <= '0;
            cnt_reg       <= '0;
            addr_reg      <= '0;
            sum_r_reg     <= '0;
            sum_g_reg     <= '0;
            sum_b_reg     <= '0;
            res_pix_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_pix_reg   <= '0;
            rsp_cnt_reg   <= '0;
        end
        else
        begin
            // a beat taken downstream clears valid unless the next one is loaded
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_FIN))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_accept)
                    begin
                        res_pix_reg <= '0;
                        cnt_reg     <= '0;
                        idx_reg     <= step_index;
                        pass_reg    <= pass_select;
                        pt_reg      <= '0;
                        unique case (kind_t'(kind))
                            KIND_READ:  state_reg <= pix_ok ? S_RDPIX : S_FIN;
                            KIND_DRAW:  state_reg <= S_SQRT;
                            KIND_WRITE: state_reg <= S_FIN;
                            KIND_NONE:  state_reg <= S_FIN;
                            default:    state_reg <= S_FIN;
                        endcase
                    end
                end

                S_RDPIX:
                begin
                    res_pix_reg <= rd_data_reg;
                    state_reg   <= S_FIN;
                end

                S_SQRT:
                begin
                    if (sq_stat.done)
                    begin
                        dist_reg  <= sq_stat.root;
                        state_reg <= S_PT;
                    end
                end

                S_PT:
                begin
                    addr_reg <= pt_a;
                    if (pt_ok)
                    begin
                        state_reg <= S_MIX;
                    end
                    else
                    begin
                        // point off the image, skipped and not counted
                        pt_reg    <= pt_reg + 2'd1;
                        state_reg <= (pt_reg == 2'd3) ? S_FIN : S_PT;
                    end
                end

                S_MIX:
                begin
                    sum_r_reg <= mix_sum(rd_data_reg[23:16], ink_red_reg, op_inv, op_sat);
                    sum_g_reg <= mix_sum(rd_data_reg[15:8], ink_green_reg, op_inv, op_sat);
                    sum_b_reg <= mix_sum(rd_data_reg[7:0], ink_blue_reg, op_inv, op_sat);
                    state_reg <= S_WRITE;
                end

                S_WRITE:
                begin
                    cnt_reg   <= cnt_reg + 3'd1;
                    pt_reg    <= pt_reg + 2'd1;
                    state_reg <= (pt_reg == 2'd3) ? S_FIN : S_PT;
                end

                S_FIN:
                begin
                    if (rsp_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        rsp_pix_reg   <= res_pix_reg;
                        rsp_cnt_reg   <= cnt_reg;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        rsp_valid_reg <= 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign read_red       = rsp_pix_reg[23:16];
    assign read_green     = rsp_pix_reg[15:8];
    assign read_blue      = rsp_pix_reg[7:0];
    assign points_blended = rsp_cnt_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_draw_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && kind == KIND_DRAW) |=> req_stall)
        else $error("request taken right after a draw step");

    a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> (state_reg == S_SQRT))
        else $error("square root finished outside its wait state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (points_blended <= 3'd4))
        else $error("more than four points blended in one step");

    a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX) |-> !mem_we)
        else $error("frame store written during the blend sum");

endmodule

`default_nettype wire
